// ----- sv/mosf_pkg.sv -----
`default_nettype none

package mosf_pkg;

    localparam int WINDOW      = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int OUT_BITS    = 12;

    // Sorted positions of the two middle entries; equal for an odd window.
    localparam int MID_LO = (WINDOW - 1) / 2;
    localparam int MID_HI = WINDOW / 2;

    // Each pass moves the largest unsorted entry onto the sorted top run.
    // Once the run reaches down to MID_LO, both middle entries are in place.
    localparam int PASSES = WINDOW - MID_LO;

    localparam int STEP_W = $clog2(WINDOW);
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SAMPLE_BITS:0]   t_sum;
    typedef logic [OUT_BITS-1:0]    t_filtered;
    typedef logic [STEP_W-1:0]      t_step;
    typedef logic [PASS_W-1:0]      t_pass;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SORT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic cmp;
        logic rot;
        logic capture;
    } t_ring_ctrl;

endpackage

`default_nettype wire

// ----- sv/mosf_if.sv -----
`default_nettype none

interface mosf_sample_if;
    logic              valid;
    logic              ready;
    mosf_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mosf_filtered_if;
    logic                valid;
    logic                ready;
    mosf_pkg::t_filtered filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ----- sv/median_of_samples_filter_top.sv -----
// Median filter over a window of mosf_pkg::WINDOW converter samples.
//
// Samples enter on i_sample (valid/ready, one request per sample). The block
// collects a full window, orders it, and sends the mean of the two middle
// values, truncated, as one request on o_filtered. Partial windows give
// nothing; the next window starts empty.
//
// While collecting, ready is high and one sample is taken per cycle. After
// the last sample of a window, ready drops while a single comparator works
// through PASSES passes over the sample ring, one compare or rotate step of
// the ring a cycle. The result then moves into the output register once that
// register is free, and o_filtered.valid rises.
//
// The output register separates the two sides: collection of the next
// window goes on while a result waits. If the receiver still holds the
// previous result when a new one is finished, the block waits with ready
// low until it is taken. Reset empties the window and drops any result.
`default_nettype none

module median_of_samples_filter_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mosf_sample_if.sink     i_sample,
    mosf_filtered_if.source o_filtered
);

    mosf_pkg::t_ring_ctrl w_ctrl;
    mosf_pkg::t_filtered  w_mean;
    logic                 w_out_free;
    logic                 r_out_valid;
    mosf_pkg::t_filtered  r_filtered;

    assign w_out_free = !r_out_valid || o_filtered.ready;

    mosf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_out_free (w_out_free),
        .o_in_ready (i_sample.ready),
        .o_ctrl     (w_ctrl)
    );

    mosf_ring u_ring (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sample (i_sample.sample),
        .o_mean   (w_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.capture) begin
            r_out_valid <= 1'b1;
        end else if (o_filtered.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.capture) begin
            r_filtered <= w_mean;
        end
    end

    assign o_filtered.valid    = r_out_valid;
    assign o_filtered.filtered = r_filtered;

endmodule

`default_nettype wire

// ----- sv/mosf_ring.sv -----
`default_nettype none

module mosf_ring (
    input  logic                 i_clk,
    input  mosf_pkg::t_ring_ctrl i_ctrl,
    input  mosf_pkg::t_sample    i_sample,
    output mosf_pkg::t_filtered  o_mean
);

    mosf_pkg::t_sample r_ring [mosf_pkg::WINDOW];
    mosf_pkg::t_sample n_ring [mosf_pkg::WINDOW];
    logic              w_head_gt;
    mosf_pkg::t_sum    w_sum;

    // The single comparator of the block: it always looks at the two head entries.
    assign w_head_gt = r_ring[0] > r_ring[1];

    always_comb begin
        n_ring = r_ring;
        if (i_ctrl.load || i_ctrl.rot) begin
            for (int i = 0; i < mosf_pkg::WINDOW - 1; i++) begin
                n_ring[i] = r_ring[i + 1];
            end
            n_ring[mosf_pkg::WINDOW - 1] = i_ctrl.load ? i_sample : r_ring[0];
        end else if (i_ctrl.cmp) begin
            // The larger one stays at the head as the running maximum, the
            // smaller one drops to the tail.
            n_ring[0] = w_head_gt ? r_ring[0] : r_ring[1];
            for (int i = 1; i < mosf_pkg::WINDOW - 1; i++) begin
                n_ring[i] = r_ring[i + 1];
            end
            n_ring[mosf_pkg::WINDOW - 1] = w_head_gt ? r_ring[1] : r_ring[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ring <= n_ring;
    end

    assign w_sum  = mosf_pkg::t_sum'(r_ring[mosf_pkg::MID_LO])
                  + mosf_pkg::t_sum'(r_ring[mosf_pkg::MID_HI]);
    assign o_mean = mosf_pkg::t_filtered'(w_sum[mosf_pkg::SAMPLE_BITS:1]);

endmodule

`default_nettype wire

// ----- sv/mosf_seq.sv -----
`default_nettype none

module mosf_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_free,
    output logic                 o_in_ready,
    output mosf_pkg::t_ring_ctrl o_ctrl
);

    localparam mosf_pkg::t_step LAST_STEP = mosf_pkg::t_step'(mosf_pkg::WINDOW - 1);
    localparam mosf_pkg::t_pass LAST_PASS = mosf_pkg::t_pass'(mosf_pkg::PASSES - 1);

    mosf_pkg::t_state r_state, n_state;
    mosf_pkg::t_step  r_fill,  n_fill;
    mosf_pkg::t_step  r_step,  n_step;
    mosf_pkg::t_pass  r_pass,  n_pass;
    mosf_pkg::t_step  w_cmp_limit;

    // Pass k compares over the unsorted part, then rotates the rest of the ring.
    assign w_cmp_limit = LAST_STEP - mosf_pkg::t_step'(r_pass);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mosf_pkg::ST_FILL;
            r_fill  <= '0;
            r_step  <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_step  <= n_step;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_step     = r_step;
        n_pass     = r_pass;
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        unique case (r_state)
            mosf_pkg::ST_FILL: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    if (r_fill == LAST_STEP) begin
                        n_fill  = '0;
                        n_step  = '0;
                        n_pass  = '0;
                        n_state = mosf_pkg::ST_SORT;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            mosf_pkg::ST_SORT: begin
                if (r_step < w_cmp_limit) begin
                    o_ctrl.cmp = 1'b1;
                end else begin
                    o_ctrl.rot = 1'b1;
                end
                if (r_step == LAST_STEP) begin
                    n_step = '0;
                    if (r_pass == LAST_PASS) begin
                        n_state = mosf_pkg::ST_DONE;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            mosf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = mosf_pkg::ST_FILL;
                end
            end
            default: begin
                n_state = mosf_pkg::ST_FILL;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ctrl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.load, o_ctrl.cmp, o_ctrl.rot, o_ctrl.capture}))
        else $error("ring control has more than one operation active");

    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mosf_pkg::ST_SORT) |-> (r_pass <= LAST_PASS))
        else $error("sort pass counter out of range");

    a_sort_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.load && r_fill == LAST_STEP)
        |=> (r_state == mosf_pkg::ST_SORT && r_pass == '0 && r_step == '0))
        else $error("full window did not start a clean sort");

    a_sort_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mosf_pkg::ST_SORT && r_step == LAST_STEP && r_pass == LAST_PASS)
        |=> (r_state == mosf_pkg::ST_DONE))
        else $error("sort did not finish after its last pass");
`endif

endmodule

`default_nettype wire
